// ===== sv/mchtu_pkg.sv =====
package mchtu_pkg;

    localparam int MAX_LINES = 1024;
    localparam int ADDR_W    = $clog2(MAX_LINES);
    localparam int CNT_W     = $clog2(MAX_LINES + 1);
    localparam int ACTION_W  = 2;
    localparam int COORD_W   = 31;
    localparam int ID_W      = 10;
    localparam int VALUE_W   = 64;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_QUERY  = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef struct packed {
        logic        [ID_W-1:0]    id;
        logic signed [COORD_W-1:0] intercept;
        logic signed [COORD_W-1:0] slope;
    } t_line;

endpackage

// ===== sv/monotone_convex_hull_trick_unit.sv =====
// Upper envelope of lines kept as a stack in a single-port line memory, one shared multiplier.
// Insert: pops the top while a dominance test finds it dominated, then pushes; clear and no-op actions stay idle.
// Query: walks forward while the next-line test finds a higher line; an empty-hull query goes straight to output.
// The rate is set by the one 32x32 multiplier and the one memory read per tested line.
// Synchronous active-low reset empties the hull, zeroes the pointer and drops any pending word;
// the line memory itself is not cleared and needs no clearing pass.
module monotone_convex_hull_trick_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [mchtu_pkg::ACTION_W-1:0]      i_action,
    input  logic signed [mchtu_pkg::COORD_W-1:0] i_slope,
    input  logic signed [mchtu_pkg::COORD_W-1:0] i_intercept,
    input  logic [mchtu_pkg::ID_W-1:0]          i_line_id,
    input  logic signed [mchtu_pkg::COORD_W-1:0] i_query_x,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [mchtu_pkg::VALUE_W-1:0] o_envelope_value,
    output logic [mchtu_pkg::ID_W-1:0]          o_best_line,
    output logic                                o_hull_empty
);
    import mchtu_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_P_RD  = 13'b0000000000010,
        S_P_M1  = 13'b0000000000100,
        S_P_M2  = 13'b0000000001000,
        S_P_CMP = 13'b0000000010000,
        S_PUSH  = 13'b0000000100000,
        S_Q_LD  = 13'b0000001000000,
        S_Q_CUR = 13'b0000010000000,
        S_Q_RD  = 13'b0000100000000,
        S_Q_M   = 13'b0001000000000,
        S_Q_CMP = 13'b0010000000000,
        S_Q_EV  = 13'b0100000000000,
        S_Q_OUT = 13'b1000000000000
    } t_state;

    t_state r_state;

    t_line r_mem [MAX_LINES];
    t_line r_rd;
    t_line r_top;
    t_line r_cur;

    logic [CNT_W-1:0]  r_count;
    logic [ADDR_W-1:0] r_ptr;
    logic [ADDR_W-1:0] r_p;

    logic signed [COORD_W-1:0] r_a;
    logic signed [COORD_W-1:0] r_b;
    logic [ID_W-1:0]           r_id;
    logic signed [COORD_W-1:0] r_x;
    logic                      r_empty_q;

    logic signed [VALUE_W-1:0] r_p1;
    logic signed [VALUE_W-1:0] r_p2;

    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_out_value;
    logic [ID_W-1:0]           r_out_id;
    logic                      r_out_empty;

    logic signed [COORD_W:0]   mul_a;
    logic signed [COORD_W:0]   mul_b;
    logic signed [VALUE_W-1:0] prod;

    logic                      rd_en;
    logic [ADDR_W-1:0]         rd_addr;
    logic [CNT_W-1:0]          cnt_m1;
    logic [CNT_W-1:0]          cnt_m2;
    logic [CNT_W-1:0]          p_inc;
    logic [CNT_W-1:0]          p_inc2;

    logic                      push_ok;
    logic                      do_write;
    logic [CNT_W-1:0]          n_count;
    logic [CNT_W-1:0]          n_count_m1;
    logic [ADDR_W-1:0]         n_ptr;
    logic [ADDR_W-1:0]         n_p_start;

    logic signed [COORD_W:0]   q_diff;
    logic signed [VALUE_W-1:0] q_rhs;
    logic signed [VALUE_W-1:0] ev_sum;
    logic                      out_free;

    assign cnt_m1 = r_count - CNT_W'(1);
    assign cnt_m2 = r_count - CNT_W'(2);
    assign p_inc  = {1'b0, r_p} + CNT_W'(1);
    assign p_inc2 = {1'b0, r_p} + CNT_W'(2);

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_envelope_value = r_out_value;
    assign o_best_line      = r_out_id;
    assign o_hull_empty     = r_out_empty;
    assign out_free         = !r_out_valid || i_ready;

    // The single multiplier: operands chosen by the sequencer state, product registered.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_P_M1: begin
                mul_a = {r_rd.intercept[COORD_W-1], r_rd.intercept} - {r_b[COORD_W-1], r_b};
                mul_b = {r_top.slope[COORD_W-1], r_top.slope}
                      - {r_rd.slope[COORD_W-1], r_rd.slope};
            end
            S_P_M2: begin
                mul_a = {r_rd.intercept[COORD_W-1], r_rd.intercept}
                      - {r_top.intercept[COORD_W-1], r_top.intercept};
                mul_b = {r_a[COORD_W-1], r_a} - {r_rd.slope[COORD_W-1], r_rd.slope};
            end
            S_Q_M: begin
                mul_a = {r_x[COORD_W-1], r_x};
                mul_b = {r_rd.slope[COORD_W-1], r_rd.slope}
                      - {r_cur.slope[COORD_W-1], r_cur.slope};
            end
            S_Q_EV: begin
                mul_a = {r_cur.slope[COORD_W-1], r_cur.slope};
                mul_b = {r_x[COORD_W-1], r_x};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_p;
        unique case (r_state)
            S_P_RD: begin
                rd_en   = 1'b1;
                rd_addr = cnt_m2[ADDR_W-1:0];
            end
            S_Q_LD: begin
                rd_en   = 1'b1;
                rd_addr = r_p;
            end
            S_Q_RD: begin
                rd_en   = 1'b1;
                rd_addr = p_inc[ADDR_W-1:0];
            end
            default: begin
                rd_en   = 1'b0;
                rd_addr = r_p;
            end
        endcase
    end

    // Push decision and pointer clamp after the pops are done.
    always_comb begin
        push_ok    = (r_count == '0) || (r_a != r_top.slope);
        do_write   = push_ok && (r_count < CNT_W'(MAX_LINES));
        n_count    = do_write ? r_count + CNT_W'(1) : r_count;
        n_count_m1 = n_count - CNT_W'(1);
        if (n_count == '0) begin
            n_ptr = '0;
        end else if ({1'b0, r_ptr} >= n_count) begin
            n_ptr = n_count_m1[ADDR_W-1:0];
        end else begin
            n_ptr = r_ptr;
        end
        if ({1'b0, r_ptr} >= r_count) begin
            n_p_start = cnt_m1[ADDR_W-1:0];
        end else begin
            n_p_start = r_ptr;
        end
    end

    assign q_diff = {r_cur.intercept[COORD_W-1], r_cur.intercept}
                  - {r_rd.intercept[COORD_W-1], r_rd.intercept};
    assign q_rhs  = {{(VALUE_W-COORD_W-1){q_diff[COORD_W]}}, q_diff};
    assign ev_sum = r_p1 + {{(VALUE_W-COORD_W){r_cur.intercept[COORD_W-1]}}, r_cur.intercept};

    always_ff @(posedge i_clk) begin
        if (r_state == S_PUSH && do_write) begin
            r_mem[r_count[ADDR_W-1:0]] <= '{id: r_id, intercept: r_b, slope: r_a};
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A word taken while the next one is being issued is replaced in the output stage.
            if (r_out_valid && i_ready && (r_state != S_Q_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_a  <= i_slope;
                        r_b  <= i_intercept;
                        r_id <= i_line_id;
                        r_x  <= i_query_x;
                        unique case (t_action'(i_action))
                            ACT_INSERT: begin
                                r_state <= (r_count > CNT_W'(1)) ? S_P_RD : S_PUSH;
                            end
                            ACT_QUERY: begin
                                r_p <= n_p_start;
                                if (r_count == '0) begin
                                    r_empty_q <= 1'b1;
                                    r_state   <= S_Q_OUT;
                                end else begin
                                    r_empty_q <= 1'b0;
                                    r_state   <= S_Q_LD;
                                end
                            end
                            ACT_CLEAR: begin
                                r_count <= '0;
                                r_ptr   <= '0;
                            end
                            ACT_NONE: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_P_RD: r_state <= S_P_M1;
                S_P_M1: begin
                    r_p1    <= prod;
                    r_state <= S_P_M2;
                end
                S_P_M2: begin
                    r_p2    <= prod;
                    r_state <= S_P_CMP;
                end
                S_P_CMP: begin
                    // The top is dominated: drop it and the line below becomes the top.
                    if (r_p1 <= r_p2) begin
                        r_count <= cnt_m1;
                        r_top   <= r_rd;
                        r_state <= (cnt_m1 > CNT_W'(1)) ? S_P_RD : S_PUSH;
                    end else begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (do_write) begin
                        r_top <= '{id: r_id, intercept: r_b, slope: r_a};
                    end
                    r_count <= n_count;
                    r_ptr   <= n_ptr;
                    r_state <= S_IDLE;
                end
                S_Q_LD: r_state <= S_Q_CUR;
                S_Q_CUR: begin
                    r_cur   <= r_rd;
                    r_state <= (p_inc < r_count) ? S_Q_RD : S_Q_EV;
                end
                S_Q_RD: r_state <= S_Q_M;
                S_Q_M: begin
                    r_p1    <= prod;
                    r_state <= S_Q_CMP;
                end
                S_Q_CMP: begin
                    // Advance while the next line lies strictly higher at x.
                    if (r_p1 > q_rhs) begin
                        r_p     <= p_inc[ADDR_W-1:0];
                        r_cur   <= r_rd;
                        r_state <= (p_inc2 < r_count) ? S_Q_RD : S_Q_EV;
                    end else begin
                        r_state <= S_Q_EV;
                    end
                end
                S_Q_EV: begin
                    r_p1    <= prod;
                    r_state <= S_Q_OUT;
                end
                S_Q_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_empty <= r_empty_q;
                        if (r_empty_q) begin
                            r_out_value <= '0;
                            r_out_id    <= '0;
                        end else begin
                            r_out_value <= ev_sum;
                            r_out_id    <= r_cur.id;
                            r_ptr       <= r_p;
                        end
                        r_state <= S_IDLE;
                    end else if (r_out_valid && i_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
